/* design/first_repeating_element_finder_defines.svh */
// Assertion macros for the first repeating element finder checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FIRST_REPEATING_ELEMENT_FINDER_DEFINES_SVH
`define FIRST_REPEATING_ELEMENT_FINDER_DEFINES_SVH

// same-cycle implication
`define FRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/frf_pkg.sv */
// Shared types and constants for the first repeating element finder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frf_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int POS_W     = 10;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] NONE_IDX = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] NONE_POS = {POS_W{1'b1}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } frf_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    overflow;
  } frf_out_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] idx;
  } frf_entry_t;

endpackage

`default_nettype wire

/* design/frf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* design/first_repeating_element_finder.sv */
// Top level of the first repeating element finder: sequencer, counters, output register.
// Depends on frf_pkg and frf_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one frame element per
//   beat, with last marking the final element. Output channel (out_valid_o /
//   out_stall_i / out_data_o) carries one beat per frame: the 1-based position of the
//   earliest element whose value repeats (-1 if none) and an overflow flag set when
//   the frame held more than MAX_ITEMS elements.
//   Each element is compared against the stored distinct values one per cycle
//   through the table RAM's single read port; a hit ends the scan early.
//   in_stall_o is high while an item is in work. The result beat of a frame shows
//   on out_valid_o the cycle after its last item finishes.
//   While the receiver stalls, the result holds in the output register; new items
//   are still taken, and a following last item waits only if that beat is unsent.
//   Reset clears the counters and the output valid flag at once; the table is
//   tracked by its fill count, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module first_repeating_element_finder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire frf_pkg::frf_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output frf_pkg::frf_out_t     out_data_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                  state_q, state_d;
  frf_pkg::frf_in_t            item_q, item_d;
  logic [frf_pkg::CNT_W-1:0]   k_q, k_d;
  logic [frf_pkg::CNT_W-1:0]   dcount_q, dcount_d;
  logic [frf_pkg::CNT_W-1:0]   icount_q, icount_d;
  logic [frf_pkg::CNT_W-1:0]   best_q, best_d;
  logic                        ovf_q, ovf_d;
  logic                        pend_q, pend_d;
  logic                        hit_q, hit_d;
  logic                        out_valid_q, out_valid_d;
  frf_pkg::frf_out_t           out_q, out_d;

  logic                        rd_en;
  logic [frf_pkg::IDX_W-1:0]   rd_addr;
  frf_pkg::frf_entry_t         rd_data;
  logic                        wr_en;
  logic [frf_pkg::IDX_W-1:0]   wr_addr;
  frf_pkg::frf_entry_t         wr_data;
  logic [frf_pkg::POS_W-1:0]   pos_wide;

  frf_ram #(
    .WIDTH ($bits(frf_pkg::frf_entry_t)),
    .DEPTH (frf_pkg::MAX_ITEMS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign pos_wide = frf_pkg::POS_W'(best_q) + frf_pkg::POS_W'(1);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    k_d         = k_q;
    dcount_d    = dcount_q;
    icount_d    = icount_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = k_q[frf_pkg::IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = dcount_q[frf_pkg::IDX_W-1:0];
    wr_data     = '{value: item_q.value, idx: icount_q[frf_pkg::IDX_W-1:0]};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          k_d     = '0;
          pend_d  = 1'b0;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_q && (rd_data.value == item_q.value)) begin
          hit_d  = 1'b1;
          pend_d = 1'b0;
          if (frf_pkg::CNT_W'(rd_data.idx) < best_q) begin
            best_d = frf_pkg::CNT_W'(rd_data.idx);
          end
          state_d = S_FINISH;
        end else if (k_q < dcount_q) begin
          rd_en  = 1'b1;
          k_d    = k_q + 1'b1;
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!item_q.last || !out_valid_q || !out_stall_i) begin
          if (icount_q == frf_pkg::MAX_CNT) begin
            ovf_d = 1'b1;
          end else begin
            if (!hit_q && (dcount_q < frf_pkg::MAX_CNT)) begin
              wr_en    = 1'b1;
              dcount_d = dcount_q + 1'b1;
            end
            icount_d = icount_q + 1'b1;
          end
          if (item_q.last) begin
            out_valid_d    = 1'b1;
            out_d.overflow = ovf_d;
            out_d.position = (best_q == frf_pkg::NONE_IDX) ? frf_pkg::NONE_POS : pos_wide;
            dcount_d = '0;
            icount_d = '0;
            best_d   = frf_pkg::NONE_IDX;
            ovf_d    = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      dcount_q    <= '0;
      icount_q    <= '0;
      best_q      <= frf_pkg::NONE_IDX;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      dcount_q    <= dcount_d;
      icount_q    <= icount_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/frf_checker.sv */
// Port-level checker for first_repeating_element_finder, bound to the top level.
// Depends on frf_pkg and first_repeating_element_finder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "first_repeating_element_finder_defines.svh"

module frf_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire frf_pkg::frf_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire frf_pkg::frf_out_t out_data_o
);

  logic in_beat;
  logic in_last_beat;

  assign in_beat      = in_valid_i && !in_stall_o;
  assign in_last_beat = in_beat && in_data_i.last;

  `FRF_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `FRF_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o))
  `FRF_ASSERT_NXT(a_busy_after_beat, in_beat, in_stall_o)
  `FRF_ASSERT_NXT(a_no_instant_result, in_last_beat && !out_valid_o, !out_valid_o)

endmodule

bind first_repeating_element_finder frf_checker u_frf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* dv/first_repeat_checker.sv */
// Checker for the first repeating element finder: predicts each frame's result
// from the accepted element beats and compares the result beats against it.
// Depends on frf_pkg.
`timescale 1ns / 1ps

module first_repeat_checker
  import frf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_stall_i,
  input  wire frf_in_t  in_data_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_stall_i,
  input  wire frf_out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic [VAL_W-1:0] seen_val   [MAX_ITEMS];
  logic [IDX_W-1:0] seen_first [MAX_ITEMS];
  int               distinct_n;
  int               element_n;
  logic [CNT_W-1:0] best_idx;
  logic             frame_ovf;
  frf_out_t         expected_results[$];
  int               fail_count = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic absorb_element(input frf_in_t beat);
    bit       hit;
    frf_out_t res;
    hit = 1'b0;
    for (int k = 0; k < distinct_n; k++) begin
      if (seen_val[k] == beat.value) begin
        hit = 1'b1;
        if (CNT_W'(seen_first[k]) < best_idx) best_idx = CNT_W'(seen_first[k]);
        break;
      end
    end
    if (element_n >= MAX_ITEMS) begin
      frame_ovf = 1'b1;
    end else begin
      if (!hit) begin
        seen_val[distinct_n]   = beat.value;
        seen_first[distinct_n] = IDX_W'(element_n);
        distinct_n++;
      end
      element_n++;
    end
    if (beat.last) begin
      res.position = (best_idx == NONE_IDX) ? NONE_POS : POS_W'(best_idx) + POS_W'(1);
      res.overflow = frame_ovf;
      expected_results.push_back(res);
      distinct_n = 0;
      element_n  = 0;
      best_idx   = NONE_IDX;
      frame_ovf  = 1'b0;
    end
  endtask

  task automatic check_result(input frf_out_t got);
    frf_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat: position=%0d overflow=%0b",
                                got.position, got.overflow));
      return;
    end
    want = expected_results.pop_front();
    if (got.position !== want.position)
      report_mismatch($sformatf("position: got %0d, want %0d", got.position, want.position));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow: got %0b, want %0b", got.overflow, want.overflow));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      distinct_n = 0;
      element_n  = 0;
      best_idx   = NONE_IDX;
      frame_ovf  = 1'b0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) absorb_element(in_data_i);
      fail_count_o <= fail_count;
      pending_o    <= expected_results.size();
    end
  end

endmodule

/* dv/tb_first_repeating_element_finder.sv */
// Testbench top for the first repeating element finder: clock, reset, frame
// stimulus with idling and hold-offs, and the final verdict.
// Depends on frf_pkg, first_repeating_element_finder and first_repeat_checker.
`timescale 1ns / 1ps

module tb_first_repeating_element_finder;
  import frf_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  frf_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  frf_out_t out_data;
  int       fail_count;
  int       pending;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int items_sent   = 0;
  int frames_sent  = 0;
  int long_frames  = 0;

  always #4 clk = ~clk;

  first_repeating_element_finder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  first_repeat_checker frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic offer_beat(input frf_in_t beat);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic offer_frame(input logic [VAL_W-1:0] vals[$]);
    frf_in_t beat;
    foreach (vals[i]) begin
      beat.value = vals[i];
      beat.last  = (i == vals.size() - 1);
      offer_beat(beat);
    end
    frames_sent++;
    if (vals.size() > MAX_ITEMS) long_frames++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return VAL_W'($urandom_range(15)) - VAL_W'(8);
      1: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // values drawn from a small pool so repeats are common
  task automatic send_short_frame();
    logic [VAL_W-1:0] pool[$];
    logic [VAL_W-1:0] vals[$];
    int               len;
    int               pool_n;
    len    = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    pool_n = $urandom_range(1, len);
    repeat (pool_n) pool.push_back(pick_value());
    repeat (len) vals.push_back(pool[$urandom_range(pool_n - 1)]);
    offer_frame(vals);
  endtask

  // longer than the table; elements past capacity often repeat earlier ones
  task automatic send_long_frame(input bit early_repeats);
    logic [VAL_W-1:0] vals[$];
    int               len;
    bit               reuse;
    len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 16);
    for (int i = 0; i < len; i++) begin
      if (i >= MAX_ITEMS) reuse = $urandom_range(1);
      else reuse = early_repeats && (i > 0) && ($urandom_range(9) == 0);
      if (reuse) vals.push_back(vals[$urandom_range(i - 1)]);
      else vals.push_back($urandom);
    end
    offer_frame(vals);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] vals[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    vals = '{32'h8000_0000};
    offer_frame(vals);
    vals = '{32'h7FFF_FFFF};
    offer_frame(vals);
    vals = '{32'h0, 32'hFFFF_FFFF, 32'h0};
    offer_frame(vals);
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 32'h7FFF_FFFF, 32'h8000_0000};
    offer_frame(vals);
    vals = '{32'h1, 32'h2, 32'h3, 32'h4, 32'h4};
    offer_frame(vals);
    vals = '{32'd10, -32'sd20, 32'd30};
    offer_frame(vals);
    vals = '{32'd7, 32'd3, 32'd3, 32'd7};
    offer_frame(vals);
    drain();

    tx_idle_pct = 35;
    rx_idle_pct = 81;
    holds_asked++;
    repeat (4) send_short_frame();
    send_long_frame(1'b1);
    while (items_sent < 560) send_short_frame();
    drain();

    tx_idle_pct = 81;
    rx_idle_pct = 35;
    send_long_frame(1'b0);
    while (items_sent < 1080) send_short_frame();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked++;
    repeat (4) send_short_frame();
    send_long_frame(1'b1);
    while (items_sent < 1600) send_short_frame();
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $display("ERROR: %0d expected results never arrived", pending);
    $display("Ran %0d elements in %0d frames, %0d of them past the %0d-entry table.",
             items_sent, frames_sent, long_frames, MAX_ITEMS);
    $display("Idling mixes: sender-heavy, receiver-heavy, none; two long receiver hold-offs.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* first_repeating_element_finder.f */
+incdir+design
design/frf_pkg.sv
design/frf_ram.sv
design/first_repeating_element_finder.sv
design/frf_checker.sv
dv/first_repeat_checker.sv
dv/tb_first_repeating_element_finder.sv
